FILE: hw/rtl/lr_pkg.sv
// Shared definitions for the line rasterizer: operation codes and the
// control bundle passed from the top level to the stepping core.
// No dependencies.
package lr_pkg;

  localparam logic OP_START = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  typedef struct packed {
    logic advance;  // the held item moves into the result register this cycle
    logic op;       // operation of the held item
  } lr_ctl_t;

endpackage

FILE: hw/rtl/line_rasterizer_top.sv
// Line rasterizer top level: input register, stepping core and result register.
// Depends on lr_pkg and lr_step.
//
// Usage: each transfer on the s_ channel carries one command. tuser = 0 starts
// a line from the endpoints in tdata and emits its first pixel; tuser = 1
// advances one pixel along the current line. Every command gives exactly one
// transfer on the m_ channel: the pixel in tdata, tuser = 1 when a pixel is
// emitted (0 for an advance while no line is active), tlast on the final pixel.
// A command accepted on s_ is registered in the input register, processed by
// lr_step and captured in the result register, which drives m_.
// Throughput: one command per cycle unless m_ stalls, set by the error update
// and position step in lr_step. A start while a line is active drops that line.
// When the receiver stalls, the result register holds and the input register
// takes one more command if empty; s_tready then falls until m_ drains.
// Reset (rst, synchronous) empties both registers and leaves the core idle.
module line_rasterizer_top import lr_pkg::*; #(
  parameter int COORD_BITS = 10
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // start_x, start_y, end_x, end_y, zero padding
  input  logic [((4*COORD_BITS+7)/8)*8-1:0]    s_tdata,
  // op
  input  logic                                 s_tuser,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // pix_x, pix_y, zero padding
  output logic [((2*COORD_BITS+7)/8)*8-1:0]    m_tdata,
  // pix_valid
  output logic                                 m_tuser,
  // last_pixel
  output logic                                 m_tlast
);

  localparam int C     = COORD_BITS;
  localparam int OUT_W = ((2*COORD_BITS+7)/8)*8;

  logic         in_valid, in_op;
  logic [C-1:0] in_sx, in_sy, in_ex, in_ey;
  logic [C-1:0] res_x, res_y;
  logic         res_valid, res_last;
  logic [C-1:0] step_x, step_y;
  logic         step_valid, step_last;
  lr_ctl_t      ctl;

  assign ctl.advance = in_valid && (!m_tvalid || m_tready);
  assign ctl.op      = in_op;
  assign s_tready    = !in_valid || ctl.advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_op <= s_tuser;
      in_sx <= s_tdata[C-1:0];
      in_sy <= s_tdata[2*C-1:C];
      in_ex <= s_tdata[3*C-1:2*C];
      in_ey <= s_tdata[4*C-1:3*C];
    end
  end

  lr_step #(.COORD_BITS(COORD_BITS)) u_step (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .start_x    (in_sx),
    .start_y    (in_sy),
    .end_x      (in_ex),
    .end_y      (in_ey),
    .pix_x      (step_x),
    .pix_y      (step_y),
    .pix_valid  (step_valid),
    .last_pixel (step_last)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (!m_tvalid || m_tready) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.advance) begin
      res_x     <= step_x;
      res_y     <= step_y;
      res_valid <= step_valid;
      res_last  <= step_last;
    end
  end

  assign m_tdata = OUT_W'({res_y, res_x});
  assign m_tuser = res_valid;
  assign m_tlast = res_last;

endmodule

FILE: hw/rtl/lr_step.sv
// Bresenham stepping core: line state registers and the combinational
// start/advance logic that produces one pixel per item.
// Depends on lr_pkg.
module lr_step import lr_pkg::*; #(
  parameter int COORD_BITS = 10
) (
  input  logic                  clk,
  input  logic                  rst,
  input  lr_ctl_t               ctl,
  input  logic [COORD_BITS-1:0] start_x,
  input  logic [COORD_BITS-1:0] start_y,
  input  logic [COORD_BITS-1:0] end_x,
  input  logic [COORD_BITS-1:0] end_y,
  output logic [COORD_BITS-1:0] pix_x,
  output logic [COORD_BITS-1:0] pix_y,
  output logic                  pix_valid,
  output logic                  last_pixel
);

  localparam int C  = COORD_BITS;
  localparam int EW = COORD_BITS + 2;
  localparam int WW = COORD_BITS + 3;

  logic [C-1:0]  cur_x, cur_y, delta_x, delta_y, steps_left;
  logic [EW-1:0] err_term;
  logic          step_neg_x, step_neg_y, x_major, busy;

  logic [C-1:0]  cur_x_next, cur_y_next, delta_x_next, delta_y_next, steps_left_next;
  logic [EW-1:0] err_term_next;
  logic          step_neg_x_next, step_neg_y_next, x_major_next, busy_next;

  logic          s_neg_x, s_neg_y, s_xmaj;
  logic [C-1:0]  s_dx, s_dy, s_dmaj, s_dmin;
  logic [C-1:0]  t_dmaj, t_dmin, t_steps;
  logic [WW-1:0] s_err, t_err_wide, t_err_ext;

  always_comb begin
    s_neg_x = end_x < start_x;
    s_neg_y = end_y < start_y;
    s_dx    = s_neg_x ? start_x - end_x : end_x - start_x;
    s_dy    = s_neg_y ? start_y - end_y : end_y - start_y;
    s_xmaj  = s_dx > s_dy;
    s_dmaj  = s_xmaj ? s_dx : s_dy;
    s_dmin  = s_xmaj ? s_dy : s_dx;
    s_err   = {2'b00, s_dmin, 1'b0} - {3'b000, s_dmaj};

    t_dmaj    = x_major ? delta_x : delta_y;
    t_dmin    = x_major ? delta_y : delta_x;
    t_err_ext = {err_term[EW-1], err_term};
    // A negative error term steps the major axis only.
    if (err_term[EW-1]) begin
      t_err_wide = t_err_ext + {2'b00, t_dmin, 1'b0};
    end else begin
      t_err_wide = t_err_ext + {2'b00, t_dmin, 1'b0} - {2'b00, t_dmaj, 1'b0};
    end
    t_steps = steps_left - 1'b1;
  end

  always_comb begin
    cur_x_next      = cur_x;
    cur_y_next      = cur_y;
    delta_x_next    = delta_x;
    delta_y_next    = delta_y;
    steps_left_next = steps_left;
    err_term_next   = err_term;
    step_neg_x_next = step_neg_x;
    step_neg_y_next = step_neg_y;
    x_major_next    = x_major;
    busy_next       = busy;
    pix_valid       = 1'b0;
    last_pixel      = 1'b0;
    if (ctl.op == OP_START) begin
      step_neg_x_next = s_neg_x;
      step_neg_y_next = s_neg_y;
      delta_x_next    = s_dx;
      delta_y_next    = s_dy;
      x_major_next    = s_xmaj;
      err_term_next   = s_err[EW-1:0];
      cur_x_next      = start_x;
      cur_y_next      = start_y;
      steps_left_next = s_dmaj;
      busy_next       = s_dmaj != '0;
      pix_valid       = 1'b1;
      last_pixel      = s_dmaj == '0;
    end else if (busy) begin
      err_term_next = t_err_wide[EW-1:0];
      if (x_major || !err_term[EW-1]) begin
        cur_x_next = step_neg_x ? cur_x - 1'b1 : cur_x + 1'b1;
      end
      if (!x_major || !err_term[EW-1]) begin
        cur_y_next = step_neg_y ? cur_y - 1'b1 : cur_y + 1'b1;
      end
      steps_left_next = t_steps;
      busy_next       = t_steps != '0;
      pix_valid       = 1'b1;
      last_pixel      = t_steps == '0;
    end
    // A tick while idle reports zeros and leaves the state alone.
    pix_x = pix_valid ? cur_x_next : '0;
    pix_y = pix_valid ? cur_y_next : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_x      <= '0;
      cur_y      <= '0;
      delta_x    <= '0;
      delta_y    <= '0;
      steps_left <= '0;
      err_term   <= '0;
      step_neg_x <= 1'b0;
      step_neg_y <= 1'b0;
      x_major    <= 1'b0;
      busy       <= 1'b0;
    end else if (ctl.advance) begin
      cur_x      <= cur_x_next;
      cur_y      <= cur_y_next;
      delta_x    <= delta_x_next;
      delta_y    <= delta_y_next;
      steps_left <= steps_left_next;
      err_term   <= err_term_next;
      step_neg_x <= step_neg_x_next;
      step_neg_y <= step_neg_y_next;
      x_major    <= x_major_next;
      busy       <= busy_next;
    end
  end

endmodule

FILE: tb/tb_line_rasterizer_top.sv
// Self-checking testbench for line_rasterizer_top: random-gap stream driver and
// monitor around a line-stepping predictor that is kept in step with every command.
// Depends on lr_pkg and the line_rasterizer_top RTL.
module tb_line_rasterizer_top;
  import lr_pkg::*;

  localparam int CB    = 10;
  localparam int ERR_W = CB + 2;
  localparam int IN_W  = ((4*CB+7)/8)*8;
  localparam int OUT_W = ((2*CB+7)/8)*8;
  localparam int MAX_C = (1 << CB) - 1;

  typedef struct packed {
    logic          hold;  // sender waits for all pixels before this command
    logic          op;
    logic [CB-1:0] x0, y0, x1, y1;
  } cmd_t;

  typedef struct packed {
    logic [CB-1:0] px, py;
    logic          valid, last;
  } pixel_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [IN_W-1:0]  s_tdata = '0;
  logic             s_tuser = 1'b0;
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;
  logic             m_tuser;
  logic             m_tlast;

  line_rasterizer_top #(.COORD_BITS(CB)) i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  always #10 clk = ~clk;

  cmd_t   cmd_q[$];
  pixel_t pixel_q[$];
  logic   in_taken = 1'b0;
  int     tx_gap = 0, tx_calm = 0, rx_gap = 0, rx_calm = 0;
  int     n_queued = 0, n_long = 0;
  int     n_mismatch = 0, n_fail = 0;
  int     n_lines = 0, n_dropped = 0, n_pixels = 0, n_idle_ticks = 0;

  // Predictor state: the line being walked.
  logic [CB-1:0]           ln_x, ln_y, ln_dx, ln_dy, ln_remain;
  logic signed [ERR_W-1:0] ln_err;
  logic                    ln_neg_x, ln_neg_y, ln_xmaj, ln_active;

  task automatic line_clear();
    ln_x = '0; ln_y = '0; ln_dx = '0; ln_dy = '0; ln_remain = '0; ln_err = '0;
    ln_neg_x = 1'b0; ln_neg_y = 1'b0; ln_xmaj = 1'b0; ln_active = 1'b0;
  endtask

  task automatic line_advance(input cmd_t c, output pixel_t p);
    logic [CB-1:0] dmaj, dmin;
    p = '0;
    if (c.op == OP_START) begin
      if (ln_active) n_dropped++;
      n_lines++;
      ln_neg_x = c.x1 < c.x0;
      ln_neg_y = c.y1 < c.y0;
      ln_dx = ln_neg_x ? c.x0 - c.x1 : c.x1 - c.x0;
      ln_dy = ln_neg_y ? c.y0 - c.y1 : c.y1 - c.y0;
      ln_xmaj = ln_dx > ln_dy;
      dmaj = ln_xmaj ? ln_dx : ln_dy;
      dmin = ln_xmaj ? ln_dy : ln_dx;
      ln_err = ERR_W'(2*int'(dmin) - int'(dmaj));
      ln_x = c.x0;
      ln_y = c.y0;
      ln_remain = dmaj;
      ln_active = dmaj != 0;
      p.px = ln_x; p.py = ln_y; p.valid = 1'b1; p.last = !ln_active;
    end else if (!ln_active) begin
      n_idle_ticks++;
    end else begin
      dmaj = ln_xmaj ? ln_dx : ln_dy;
      dmin = ln_xmaj ? ln_dy : ln_dx;
      // The minor axis steps only when the error term is not negative.
      if (ln_err < 0) begin
        ln_err = ERR_W'(int'(ln_err) + 2*int'(dmin));
        if (ln_xmaj) ln_x = ln_neg_x ? ln_x - 1'b1 : ln_x + 1'b1;
        else         ln_y = ln_neg_y ? ln_y - 1'b1 : ln_y + 1'b1;
      end else begin
        ln_err = ERR_W'(int'(ln_err) + 2*int'(dmin) - 2*int'(dmaj));
        ln_x = ln_neg_x ? ln_x - 1'b1 : ln_x + 1'b1;
        ln_y = ln_neg_y ? ln_y - 1'b1 : ln_y + 1'b1;
      end
      ln_remain = ln_remain - 1'b1;
      p.px = ln_x; p.py = ln_y; p.valid = 1'b1; p.last = 1'b0;
      if (ln_remain == 0) begin
        ln_active = 1'b0;
        p.last = 1'b1;
      end
    end
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int pick_coord();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 0;
    if (r == 1) return MAX_C;
    return $urandom_range(0, MAX_C);
  endfunction

  function automatic int near_coord(input int c);
    int d;
    d = $urandom_range(0, 16);
    if (($urandom_range(0, 1) == 1 && c >= d) || c + d > MAX_C) return c - d;
    return c + d;
  endfunction

  task automatic add_start(input logic hold, input int x0, input int y0, input int x1,
                           input int y1);
    cmd_t c;
    c.hold = hold; c.op = OP_START;
    c.x0 = CB'(x0); c.y0 = CB'(y0); c.x1 = CB'(x1); c.y1 = CB'(y1);
    cmd_q.push_back(c);
    n_queued++;
  endtask

  task automatic add_ticks(input int count);
    cmd_t c;
    for (int i = 0; i < count; i++) begin
      // Coordinate bits of an advance are junk; the block must ignore them.
      c = cmd_t'({$urandom(), $urandom()});
      c.hold = 1'b0;
      c.op = OP_TICK;
      cmd_q.push_back(c);
      n_queued++;
    end
  endtask

  // Driver: inputs change on the falling edge only.
  always @(negedge clk) begin
    cmd_t            c;
    logic            nv, nu;
    logic [IN_W-1:0] nd;
    nv = s_tvalid;
    nu = s_tuser;
    nd = s_tdata;
    if (!rst && (!s_tvalid || in_taken)) begin
      nv = 1'b0;
      if (tx_gap > 0) begin
        tx_gap--;
      end else if (cmd_q.size() > 0 && !(cmd_q[0].hold && pixel_q.size() != 0)) begin
        c = cmd_q.pop_front();
        nv = 1'b1;
        nu = c.op;
        nd = IN_W'({c.y1, c.x1, c.y0, c.x0});
        if (tx_calm > 0) begin
          tx_calm--;
        end else begin
          tx_gap = pick_gap();
          if ($urandom_range(0, 39) == 0) tx_calm = $urandom_range(20, 80);
        end
      end
    end
    s_tvalid <= nv;
    s_tuser  <= nu;
    s_tdata  <= nd;
  end

  // Receiver back-pressure, independent of the sender.
  always @(negedge clk) begin
    logic nr;
    if (rx_gap > 0) begin
      nr = 1'b0;
      rx_gap--;
    end else begin
      nr = 1'b1;
      if (rx_calm > 0) begin
        rx_calm--;
      end else begin
        rx_gap = pick_gap();
        if ($urandom_range(0, 39) == 0) rx_calm = $urandom_range(20, 80);
      end
    end
    m_tready <= nr;
  end

  // Monitor: predict on every accepted command, check every accepted pixel.
  always @(posedge clk) begin
    cmd_t   c;
    pixel_t want, got;
    if (rst) begin
      in_taken <= 1'b0;
      line_clear();
    end else begin
      in_taken <= s_tvalid && s_tready;
      if (s_tvalid && s_tready) begin
        c.hold = 1'b0;
        c.op = s_tuser;
        {c.y1, c.x1, c.y0, c.x0} = s_tdata[4*CB-1:0];
        line_advance(c, want);
        pixel_q.push_back(want);
      end
      if (m_tvalid && m_tready) begin
        got.px = m_tdata[CB-1:0];
        got.py = m_tdata[2*CB-1:CB];
        got.valid = m_tuser;
        got.last = m_tlast;
        if (pixel_q.size() == 0) begin
          n_fail++;
          if (n_fail <= 10) $display("unexpected pixel transfer x=%0d y=%0d v=%b l=%b",
                                     got.px, got.py, got.valid, got.last);
        end else begin
          want = pixel_q.pop_front();
          n_pixels++;
          if (got.px !== want.px || got.py !== want.py || got.valid !== want.valid ||
              got.last !== want.last) begin
            n_mismatch++;
            n_fail++;
            if (n_mismatch <= 10)
              $display("pixel %0d mismatch: expected x=%0d y=%0d v=%b l=%b, got x=%0d y=%0d v=%b l=%b",
                       n_pixels, want.px, want.py, want.valid, want.last,
                       got.px, got.py, got.valid, got.last);
          end
        end
      end
    end
  end

  initial begin
    int kind, x0, y0, x1, y1, major, ticks, v;
    logic hold;
    // Tick with no line, then zero-length lines at both corners.
    add_ticks(1);
    add_start(1'b0, 0, 0, 0, 0);
    add_ticks(1);
    add_start(1'b0, MAX_C, MAX_C, MAX_C, MAX_C);
    // Shallow line with positive steps, run past its end.
    add_start(1'b0, 0, 0, 5, 2);
    add_ticks(6);
    // Full-range diagonal, dropped by the next start.
    add_start(1'b1, 0, MAX_C, MAX_C, 0);
    add_ticks(2);
    // Steep line with negative steps.
    add_start(1'b0, 10, 10, 8, 4);
    add_ticks(6);
    // Equal deltas: y is the major axis.
    add_start(1'b0, 3, 3, 0, 0);
    add_ticks(3);

    while (n_queued < 1625) begin
      kind = $urandom_range(0, 99);
      hold = ($urandom_range(0, 149) == 0);
      if (kind < 80 || (kind >= 98 && n_long >= 2)) begin
        x0 = pick_coord(); y0 = pick_coord();
        x1 = near_coord(x0); y1 = near_coord(y0);
      end else if (kind < 92 || kind >= 98) begin
        x0 = $urandom_range(0, MAX_C); y0 = $urandom_range(0, MAX_C);
        x1 = $urandom_range(0, MAX_C); y1 = $urandom_range(0, MAX_C);
      end
      if (kind >= 92 && kind < 98) begin
        add_ticks($urandom_range(1, 3));
      end else begin
        major = (x1 > x0 ? x1 - x0 : x0 - x1);
        if ((y1 > y0 ? y1 - y0 : y0 - y1) > major) major = (y1 > y0 ? y1 - y0 : y0 - y1);
        v = $urandom_range(0, 9);
        if (kind >= 98 && n_long < 2) begin
          n_long++;
          ticks = major;
        end else if (kind >= 80) ticks = $urandom_range(0, 12);
        else if (v == 0) ticks = $urandom_range(0, major);
        else if (v == 1) ticks = major + $urandom_range(1, 3);
        else ticks = major;
        add_start(hold, x0, y0, x1, y1);
        add_ticks(ticks);
      end
    end

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    while (cmd_q.size() != 0 || s_tvalid) @(posedge clk);
    while (pixel_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (pixel_q.size() != 0) begin
      n_fail++;
      $display("%0d pixels never arrived", pixel_q.size());
    end
    $display("Ran %0d commands: %0d lines started, %0d dropped mid-line by a new start,",
             n_queued, n_lines, n_dropped);
    $display("%0d pixel transfers checked, %0d advances with no line active.",
             n_pixels, n_idle_ticks);
    if (n_fail == 0) begin
      $display("tb_line_rasterizer_top: clean");
    end else begin
      $display("%0d failures", n_fail);
      $display("tb_line_rasterizer_top: errors");
    end
    $finish;
  end

  initial begin
    #30_000_000;
    $display("timeout with %0d commands and %0d pixels outstanding",
             cmd_q.size(), pixel_q.size());
    $display("tb_line_rasterizer_top: errors");
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/lr_pkg.sv
hw/rtl/lr_step.sv
hw/rtl/line_rasterizer_top.sv
tb/tb_line_rasterizer_top.sv
